// ----- rtl/core/skat_pkg.sv -----
package skat_pkg;

  localparam int CAPACITY_DEF = 32;

  localparam int KEY_W  = 32;
  localparam int AMT_W  = 32;
  localparam int CNT_W  = 32;
  localparam int BAL_W  = 48;
  localparam int TOT_W  = 6;
  localparam int STAT_W = 2;

  localparam logic [BAL_W-1:0] BAL_MAX = {1'b0, {(BAL_W-1){1'b1}}};
  localparam logic [BAL_W-1:0] BAL_MIN = {1'b1, {(BAL_W-1){1'b0}}};

  typedef enum logic [STAT_W-1:0] {
    ST_MERGED   = 2'd0,
    ST_INSERTED = 2'd1,
    ST_DROPPED  = 2'd2,
    ST_REPORT   = 2'd3
  } status_t;

  // one table entry
  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [CNT_W-1:0] count;
    logic [BAL_W-1:0] bal;
  } entry_t;

  // shared unit results
  typedef struct packed {
    logic             key_eq;
    logic             key_gt;
    entry_t           merged;
    logic [BAL_W-1:0] delta;
  } alu_res_t;

endpackage

// ----- rtl/core/skat_alu.sv -----
module skat_alu (
  input  skat_pkg::entry_t           cur,
  input  logic [skat_pkg::KEY_W-1:0] key,
  input  logic [skat_pkg::AMT_W-1:0] amount,
  input  logic                       is_debit,
  output skat_pkg::alu_res_t         res
);

  localparam int SW = skat_pkg::BAL_W + 1;

  logic [SW-1:0] mag_w;
  logic [SW-1:0] delta_w;
  logic [SW-1:0] sum_w;

  always_comb begin
    mag_w   = SW'(amount);
    delta_w = is_debit ? (~mag_w + SW'(1)) : mag_w;
    sum_w   = {cur.bal[skat_pkg::BAL_W-1], cur.bal} + delta_w;

    res.key_eq     = (cur.key == key);
    res.key_gt     = (cur.key > key);
    res.delta      = delta_w[skat_pkg::BAL_W-1:0];
    res.merged.key = cur.key;
    // visit count sticks at all ones
    res.merged.count = (&cur.count) ? cur.count : cur.count + skat_pkg::CNT_W'(1);
    // sign bits disagree: overflow, clamp toward the sign of the true sum
    if (sum_w[SW-1] != sum_w[SW-2]) begin
      res.merged.bal = sum_w[SW-1] ? skat_pkg::BAL_MIN : skat_pkg::BAL_MAX;
    end else begin
      res.merged.bal = sum_w[skat_pkg::BAL_W-1:0];
    end
  end

endmodule

// ----- rtl/core/sorted_key_accumulate_table_top.sv -----
// Channel  | Handshake          | Payload
// ---------+--------------------+-----------------------------------------------
// input    | in_valid/in_stall  | in_action, in_client_key, in_amount, in_is_debit
// result   | out_valid/out_stall| out_status, out_is_header, out_entry_total,
//          |                    | out_key, out_visit_count, out_balance, out_last
//
// One item at a time; in_stall is low only while the sequencer is idle.
// Record: accept in idle, then a table read and a compare per entry scanned,
//   a read and a write per entry shifted up on insert, and a final step that
//   posts the status (and writes the entry on insert or merge).
// Report: header first, then a read and a post per entry.
// A result waits in the output register while out_stall is high; the next
//   item is taken meanwhile, and the sequencer only waits when it has a new
//   result to post. rst_n is synchronous; the table itself is not cleared,
//   only the occupancy count.
module sorted_key_accumulate_table_top #(
  parameter int CAPACITY = skat_pkg::CAPACITY_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,

  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        in_action,
  input  logic [skat_pkg::KEY_W-1:0]  in_client_key,
  input  logic [skat_pkg::AMT_W-1:0]  in_amount,
  input  logic                        in_is_debit,

  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [skat_pkg::STAT_W-1:0] out_status,
  output logic                        out_is_header,
  output logic [skat_pkg::TOT_W-1:0]  out_entry_total,
  output logic [skat_pkg::KEY_W-1:0]  out_key,
  output logic [skat_pkg::CNT_W-1:0]  out_visit_count,
  output logic [skat_pkg::BAL_W-1:0]  out_balance,
  output logic                        out_last
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  typedef enum logic [10:0] {
    S_IDLE     = 11'b000_0000_0001,
    S_SCAN_RD  = 11'b000_0000_0010,
    S_SCAN_CMP = 11'b000_0000_0100,
    S_MERGE    = 11'b000_0000_1000,
    S_DROP     = 11'b000_0001_0000,
    S_SHIFT_RD = 11'b000_0010_0000,
    S_SHIFT_WR = 11'b000_0100_0000,
    S_INS_WR   = 11'b000_1000_0000,
    S_HDR      = 11'b001_0000_0000,
    S_RPT_RD   = 11'b010_0000_0000,
    S_RPT_LD   = 11'b100_0000_0000
  } state_t;

  state_t state_r, state_nxt;

  logic [CW-1:0] occ_r, occ_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] pos_r, pos_nxt;

  logic [skat_pkg::KEY_W-1:0] key_r, key_nxt;
  logic [skat_pkg::AMT_W-1:0] amt_r, amt_nxt;
  logic                       debit_r, debit_nxt;

  // entry table: one write, one registered read per cycle
  skat_pkg::entry_t mem [CAPACITY];
  skat_pkg::entry_t rd_data_r;
  skat_pkg::entry_t wr_data;
  logic             rd_en, wr_en;
  logic [AW-1:0]    rd_addr, wr_addr;

  skat_pkg::alu_res_t alu_res;

  // output register
  logic                        out_valid_r, out_valid_nxt;
  logic [skat_pkg::STAT_W-1:0] out_status_r, out_status_nxt;
  logic                        out_hdr_r, out_hdr_nxt;
  logic [skat_pkg::TOT_W-1:0]  out_tot_r, out_tot_nxt;
  logic [skat_pkg::KEY_W-1:0]  out_key_r, out_key_nxt;
  logic [skat_pkg::CNT_W-1:0]  out_cnt_r, out_cnt_nxt;
  logic [skat_pkg::BAL_W-1:0]  out_bal_r, out_bal_nxt;
  logic                        out_last_r, out_last_nxt;

  logic          out_free;
  logic          out_load;
  logic [CW-1:0] idx_p1;
  logic [CW-1:0] idx_m1;
  logic [CW-1:0] pos_v;
  logic          ins_now;

  skat_alu u_alu (
    .cur      (rd_data_r),
    .key      (key_r),
    .amount   (amt_r),
    .is_debit (debit_r),
    .res      (alu_res)
  );

  assign in_stall = (state_r != S_IDLE);
  assign out_free = !out_valid_r || !out_stall;
  assign idx_p1   = idx_r + CW'(1);
  assign idx_m1   = idx_r - CW'(1);

  always_comb begin
    state_nxt = state_r;
    occ_nxt   = occ_r;
    idx_nxt   = idx_r;
    pos_nxt   = pos_r;
    key_nxt   = key_r;
    amt_nxt   = amt_r;
    debit_nxt = debit_r;

    rd_en   = 1'b0;
    wr_en   = 1'b0;
    rd_addr = idx_r[AW-1:0];
    wr_addr = idx_r[AW-1:0];
    wr_data = rd_data_r;

    out_load       = 1'b0;
    out_status_nxt = out_status_r;
    out_hdr_nxt    = 1'b0;
    out_tot_nxt    = skat_pkg::TOT_W'(occ_r);
    out_key_nxt    = key_r;
    out_cnt_nxt    = '0;
    out_bal_nxt    = '0;
    out_last_nxt   = 1'b1;

    pos_v   = idx_r;
    ins_now = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          key_nxt   = in_client_key;
          amt_nxt   = in_amount;
          debit_nxt = in_is_debit;
          idx_nxt   = '0;
          if (in_action) begin
            state_nxt = S_HDR;
          end else if (occ_r == '0) begin
            pos_nxt   = '0;
            state_nxt = S_INS_WR;
          end else begin
            state_nxt = S_SCAN_RD;
          end
        end
      end

      S_SCAN_RD: begin
        rd_en     = 1'b1;
        state_nxt = S_SCAN_CMP;
      end

      S_SCAN_CMP: begin
        if (alu_res.key_eq) begin
          pos_nxt   = idx_r;
          state_nxt = S_MERGE;
        end else if (alu_res.key_gt) begin
          pos_v   = idx_r;
          ins_now = 1'b1;
        end else if (idx_p1 == occ_r) begin
          pos_v   = occ_r;
          ins_now = 1'b1;
        end else begin
          idx_nxt   = idx_p1;
          state_nxt = S_SCAN_RD;
        end
        // key absent: drop when full, else open a slot at pos_v
        if (ins_now) begin
          pos_nxt = pos_v;
          if (occ_r == CW'(CAPACITY)) begin
            state_nxt = S_DROP;
          end else if (occ_r > pos_v) begin
            idx_nxt   = occ_r;
            state_nxt = S_SHIFT_RD;
          end else begin
            state_nxt = S_INS_WR;
          end
        end
      end

      S_SHIFT_RD: begin
        rd_en     = 1'b1;
        rd_addr   = idx_m1[AW-1:0];
        state_nxt = S_SHIFT_WR;
      end

      S_SHIFT_WR: begin
        wr_en   = 1'b1;
        idx_nxt = idx_m1;
        if (idx_m1 > pos_r) begin
          state_nxt = S_SHIFT_RD;
        end else begin
          state_nxt = S_INS_WR;
        end
      end

      S_INS_WR: begin
        if (out_free) begin
          wr_en          = 1'b1;
          wr_addr        = pos_r[AW-1:0];
          wr_data.key    = key_r;
          wr_data.count  = skat_pkg::CNT_W'(1);
          wr_data.bal    = alu_res.delta;
          occ_nxt        = occ_r + CW'(1);
          out_load       = 1'b1;
          out_status_nxt = skat_pkg::ST_INSERTED;
          out_tot_nxt    = skat_pkg::TOT_W'(occ_r + CW'(1));
          out_cnt_nxt    = skat_pkg::CNT_W'(1);
          out_bal_nxt    = alu_res.delta;
          state_nxt      = S_IDLE;
        end
      end

      S_MERGE: begin
        if (out_free) begin
          wr_en          = 1'b1;
          wr_addr        = pos_r[AW-1:0];
          wr_data        = alu_res.merged;
          out_load       = 1'b1;
          out_status_nxt = skat_pkg::ST_MERGED;
          out_cnt_nxt    = alu_res.merged.count;
          out_bal_nxt    = alu_res.merged.bal;
          state_nxt      = S_IDLE;
        end
      end

      S_DROP: begin
        if (out_free) begin
          out_load       = 1'b1;
          out_status_nxt = skat_pkg::ST_DROPPED;
          state_nxt      = S_IDLE;
        end
      end

      S_HDR: begin
        if (out_free) begin
          out_load       = 1'b1;
          out_status_nxt = skat_pkg::ST_REPORT;
          out_hdr_nxt    = 1'b1;
          out_key_nxt    = '0;
          out_last_nxt   = (occ_r == '0);
          state_nxt      = (occ_r == '0) ? S_IDLE : S_RPT_RD;
        end
      end

      S_RPT_RD: begin
        rd_en     = 1'b1;
        state_nxt = S_RPT_LD;
      end

      S_RPT_LD: begin
        if (out_free) begin
          out_load       = 1'b1;
          out_status_nxt = skat_pkg::ST_REPORT;
          out_key_nxt    = rd_data_r.key;
          out_cnt_nxt    = rd_data_r.count;
          out_bal_nxt    = rd_data_r.bal;
          out_last_nxt   = (idx_p1 == occ_r);
          idx_nxt        = idx_p1;
          state_nxt      = (idx_p1 == occ_r) ? S_IDLE : S_RPT_RD;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      occ_r       <= occ_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r   <= idx_nxt;
    pos_r   <= pos_nxt;
    key_r   <= key_nxt;
    amt_r   <= amt_nxt;
    debit_r <= debit_nxt;
    if (out_load) begin
      out_status_r <= out_status_nxt;
      out_hdr_r    <= out_hdr_nxt;
      out_tot_r    <= out_tot_nxt;
      out_key_r    <= out_key_nxt;
      out_cnt_r    <= out_cnt_nxt;
      out_bal_r    <= out_bal_nxt;
      out_last_r   <= out_last_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_is_header   = out_hdr_r;
  assign out_entry_total = out_tot_r;
  assign out_key         = out_key_r;
  assign out_visit_count = out_cnt_r;
  assign out_balance     = out_bal_r;
  assign out_last        = out_last_r;

`ifndef NO_ASSERTIONS
  // occupancy stays within the table
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= CW'(CAPACITY))
    else $error("occupancy above capacity");

  // occupancy only ever grows by one entry
  a_occ_step: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && (occ_r != $past(occ_r))) |-> (occ_r == $past(occ_r) + CW'(1)))
    else $error("occupancy changed by other than one");

  // table writes never land past the first free slot
  a_wr_range: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (CW'(wr_addr) <= occ_r))
    else $error("table write beyond occupancy");

  // the scan only reads occupied entries
  a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN_RD) |-> (idx_r < occ_r))
    else $error("scan past occupied entries");
`endif

endmodule

// ----- verif/sorted_key_accumulate_table_top_tb.sv -----
module sorted_key_accumulate_table_top_tb;

  localparam int DEPTH = skat_pkg::CAPACITY_DEF;

  localparam int KEY_W  = skat_pkg::KEY_W;
  localparam int AMT_W  = skat_pkg::AMT_W;
  localparam int CNT_W  = skat_pkg::CNT_W;
  localparam int BAL_W  = skat_pkg::BAL_W;
  localparam int TOT_W  = skat_pkg::TOT_W;
  localparam int STAT_W = skat_pkg::STAT_W;

  // item codes
  localparam logic ACT_RECORD = 1'b0;
  localparam logic ACT_REPORT = 1'b1;
  localparam logic CREDIT     = 1'b0;
  localparam logic DEBIT      = 1'b1;

  // hard stop, several times the slowest legal run
  localparam longint TIMEOUT = 64'd4_000_000;
  // quiet tail after the last expected line, well past a full-table insert
  localparam int TAIL_CYCLES = 300;

  // one expected line on the result channel
  typedef struct {
    skat_pkg::status_t status;
    logic              is_header;
    logic [TOT_W-1:0]  total;
    logic [KEY_W-1:0]  key;
    logic [CNT_W-1:0]  visits;
    logic [BAL_W-1:0]  bal;
    logic              last;
  } ledger_line_t;

  // Mirror of the client table plus the queue of lines it must produce.
  class ledger_checker;
    logic [KEY_W-1:0]        keys   [DEPTH];
    logic [CNT_W-1:0]        visits [DEPTH];
    logic signed [BAL_W-1:0] bals   [DEPTH];
    int unsigned             occ;
    ledger_line_t            expected_lines [$];
    int unsigned             errors;

    function new();
      occ    = 0;
      errors = 0;
    endfunction

    function void post(skat_pkg::status_t st, logic hdr, logic [KEY_W-1:0] key,
                       logic [CNT_W-1:0] cnt, logic [BAL_W-1:0] bal, logic last);
      ledger_line_t l;
      l.status    = st;
      l.is_header = hdr;
      l.total     = TOT_W'(occ);
      l.key       = key;
      l.visits    = cnt;
      l.bal       = bal;
      l.last      = last;
      expected_lines.push_back(l);
    endfunction

    // predict the lines caused by one accepted item and update the mirror
    function void note_item(logic action, logic [KEY_W-1:0] key,
                            logic [AMT_W-1:0] amt, logic debit);
      longint      delta;
      longint      sum;
      longint      hi;
      longint      lo;
      int unsigned pos;
      int unsigned i;
      hi    = $signed(skat_pkg::BAL_MAX);
      lo    = $signed(skat_pkg::BAL_MIN);
      delta = longint'({32'd0, amt});
      if (debit) delta = -delta;

      if (action == ACT_REPORT) begin
        post(skat_pkg::ST_REPORT, 1'b1, '0, '0, '0, occ == 0);
        for (i = 0; i < occ; i++)
          post(skat_pkg::ST_REPORT, 1'b0, keys[i], visits[i], bals[i], i + 1 == occ);
        return;
      end

      pos = 0;
      while (pos < occ && keys[pos] < key) pos++;

      if (pos < occ && keys[pos] == key) begin
        if (visits[pos] != '1) visits[pos] = visits[pos] + 1;
        sum = bals[pos] + delta;
        if (sum > hi) sum = hi;
        if (sum < lo) sum = lo;
        bals[pos] = sum[BAL_W-1:0];
        post(skat_pkg::ST_MERGED, 1'b0, key, visits[pos], bals[pos], 1'b1);
      end else if (occ >= DEPTH) begin
        post(skat_pkg::ST_DROPPED, 1'b0, key, '0, '0, 1'b1);
      end else begin
        for (i = occ; i > pos; i--) begin
          keys[i]   = keys[i-1];
          visits[i] = visits[i-1];
          bals[i]   = bals[i-1];
        end
        keys[pos]   = key;
        visits[pos] = 1;
        bals[pos]   = delta[BAL_W-1:0];
        occ++;
        post(skat_pkg::ST_INSERTED, 1'b0, key, 1, delta[BAL_W-1:0], 1'b1);
      end
    endfunction

    function void compare(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        errors++;
        $error("%s: expected %0h, got %0h", name, want, got);
      end
    endfunction

    function void check_line(logic [STAT_W-1:0] st, logic hdr, logic [TOT_W-1:0] total,
                             logic [KEY_W-1:0] key, logic [CNT_W-1:0] cnt,
                             logic [BAL_W-1:0] bal, logic last);
      ledger_line_t w;
      if (expected_lines.size() == 0) begin
        errors++;
        $error("unexpected result line, key %0h", key);
        return;
      end
      w = expected_lines.pop_front();
      compare("status", 64'(w.status), 64'(st));
      compare("is_header", 64'(w.is_header), 64'(hdr));
      compare("entry_total", 64'(w.total), 64'(total));
      compare("out_key", 64'(w.key), 64'(key));
      compare("visit_count", 64'(w.visits), 64'(cnt));
      compare("balance", 64'(w.bal), 64'(bal));
      compare("last", 64'(w.last), 64'(last));
    endfunction
  endclass

  // DUT signals; every input is known from time zero
  logic                 clk           = 1'b0;
  logic                 rst_n         = 1'b0;
  logic                 in_valid      = 1'b0;
  logic                 in_stall;
  logic                 in_action     = 1'b0;
  logic [KEY_W-1:0]     in_client_key = '0;
  logic [AMT_W-1:0]     in_amount     = '0;
  logic                 in_is_debit   = 1'b0;
  logic                 out_valid;
  logic                 out_stall     = 1'b0;
  logic [STAT_W-1:0]    out_status;
  logic                 out_is_header;
  logic [TOT_W-1:0]     out_entry_total;
  logic [KEY_W-1:0]     out_key;
  logic [CNT_W-1:0]     out_visit_count;
  logic [BAL_W-1:0]     out_balance;
  logic                 out_last;

  ledger_checker ledger = new();

  // quiet = no sender gaps and no receiver stalls (used for the directed run)
  bit               quiet       = 1'b0;
  int               burst_left  = 0;
  int               stall_run   = 0;
  bit               stall_now   = 1'b0;
  logic [KEY_W-1:0] key_pool [20];

  sorted_key_accumulate_table_top #(.CAPACITY(DEPTH)) i_dut (.*);

  always #2 clk = ~clk;

  // Receiver: alternating stall and free runs of random length; now and then
  // a long free stretch so results also drain back to back.
  always @(posedge clk) begin
    if (stall_run == 0) begin
      stall_now = !stall_now;
      if (stall_now) stall_run = $urandom_range(1, 8);
      else if ($urandom_range(0, 5) == 0) stall_run = $urandom_range(40, 150);
      else stall_run = $urandom_range(1, 12);
    end else begin
      stall_run--;
    end
    out_stall <= stall_now && !quiet;
  end

  // Result monitor: a line moves when valid is high and stall is low.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      ledger.check_line(out_status, out_is_header, out_entry_total, out_key,
                        out_visit_count, out_balance, out_last);
  end

  // Present one item, hold it until taken, then maybe open a gap.
  // A burst keeps valid high across items so valid only gets one update per edge.
  task automatic send_item(input logic act, input logic [KEY_W-1:0] key,
                           input logic [AMT_W-1:0] amt, input logic deb);
    int gap;
    in_valid      <= 1'b1;
    in_action     <= act;
    in_client_key <= key;
    in_amount     <= amt;
    in_is_debit   <= deb;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    ledger.note_item(act, key, amt, deb);
    if (!quiet) begin
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        if ($urandom_range(0, 7) == 0) burst_left = $urandom_range(20, 60);
        else burst_left = $urandom_range(0, 10);
        gap = $urandom_range(1, 14);
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // Hold off the sender until every predicted line has come out.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (ledger.expected_lines.size() != 0) @(posedge clk);
  endtask

  function automatic logic [AMT_W-1:0] pick_amount();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return $urandom_range(0, 255);
      default: return $urandom;
    endcase
  endfunction

  // About two in five keys already held (merges), some extremes, the rest from a
  // small pool or fully random so the table fills and starts dropping.
  function automatic logic [KEY_W-1:0] pick_key(bit use_pool);
    int r;
    r = $urandom_range(0, 99);
    if (r < 40 && ledger.occ > 0) return ledger.keys[$urandom_range(0, ledger.occ - 1)];
    if (r < 50) begin
      if ($urandom_range(0, 1)) return $urandom_range(0, 3);
      return 32'hFFFF_FFFF - $urandom_range(0, 3);
    end
    if (use_pool) return key_pool[$urandom_range(0, 19)];
    return $urandom;
  endfunction

  task automatic random_item(bit use_pool);
    if ($urandom_range(0, 99) < 5)
      send_item(ACT_REPORT, $urandom, $urandom, 1'($urandom_range(0, 1)));
    else
      send_item(ACT_RECORD, pick_key(use_pool), pick_amount(), 1'($urandom_range(0, 1)));
  endtask

  initial begin
    int i;
    for (i = 0; i < 20; i++) key_pool[i] = $urandom;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // report on an empty table: header only, marked last
    send_item(ACT_REPORT, '1, '1, DEBIT);
    wait_drained();

    // directed, back to back with no stalls: key extremes, front/back/middle
    // inserts, zero-amount merges
    quiet = 1'b1;
    send_item(ACT_REPORT, '0, '0, CREDIT);
    send_item(ACT_RECORD, 32'h0000_0000, 32'hFFFF_FFFF, CREDIT);
    send_item(ACT_RECORD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, DEBIT);
    send_item(ACT_RECORD, 32'h0000_0000, 32'h0000_0000, DEBIT);
    send_item(ACT_RECORD, 32'hFFFF_FFFF, 32'h0000_0000, CREDIT);
    send_item(ACT_RECORD, 32'h8000_0000, 32'hAAAA_AAAA, CREDIT);
    send_item(ACT_RECORD, 32'h7FFF_FFFF, 32'h5555_5555, DEBIT);
    send_item(ACT_RECORD, 32'h8000_0000, 32'h5555_5555, DEBIT);
    send_item(ACT_RECORD, 32'h0000_0001, 32'h0000_0001, CREDIT);
    send_item(ACT_RECORD, 32'hFFFF_FFFE, 32'hFFFF_FFFF, DEBIT);
    send_item(ACT_RECORD, 32'h5555_5555, 32'h8000_0000, CREDIT);
    send_item(ACT_RECORD, 32'hAAAA_AAAA, 32'h7FFF_FFFF, DEBIT);
    send_item(ACT_REPORT, '0, '0, CREDIT);
    wait_drained();
    quiet = 1'b0;

    // random, keys from a small pool so merges dominate
    for (i = 0; i < 100; i++) random_item(1'b1);
    wait_drained();
    for (i = 0; i < 100; i++) random_item(1'b1);

    // fill to capacity with fresh keys, then a full report
    while (ledger.occ < DEPTH)
      send_item(ACT_RECORD, $urandom, pick_amount(), 1'($urandom_range(0, 1)));
    send_item(ACT_REPORT, $urandom, $urandom, 1'($urandom_range(0, 1)));

    // random on a full table: merges, drops and full reports
    for (i = 0; i < 125; i++) random_item(1'b0);
    wait_drained();
    for (i = 0; i < 125; i++) random_item(1'b0);

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (ledger.errors == 0 && ledger.expected_lines.size() == 0)
      $display("sorted_key_accumulate_table_top: match");
    else
      $display("sorted_key_accumulate_table_top: mismatch");
    $finish;
  end

  initial begin
    #(TIMEOUT);
    $display("sorted_key_accumulate_table_top: mismatch");
    $finish;
  end

endmodule
